### rtl/frame_slot_manager_defines.svh
// Assertion helpers for the frame slot manager.
`ifndef FRAME_SLOT_MANAGER_DEFINES_SVH
`define FRAME_SLOT_MANAGER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FSMGR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FSMGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fsmgr_pkg.sv
package fsmgr_pkg;

    localparam int SLOTS = 4;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] MODE_INSTALL = 3'd0;
    localparam logic [2:0] MODE_QUIESCE = 3'd1;
    localparam logic [2:0] MODE_BEGIN   = 3'd2;
    localparam logic [2:0] MODE_PUBLISH = 3'd3;
    localparam logic [2:0] MODE_ACQUIRE = 3'd4;
    localparam logic [2:0] MODE_RELEASE = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVAL   = 3'd1;
    localparam logic [2:0] ST_NOSLOTS = 3'd2;
    localparam logic [2:0] ST_NOFREE  = 3'd3;
    localparam logic [2:0] ST_BUSY    = 3'd4;
    localparam logic [2:0] ST_NOFRAME = 3'd5;

    localparam logic [7:0] REF_MAX = 8'hFF;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  slot_count;
        logic [23:0] capacity;
        logic [2:0]  payload_kind;
        logic [3:0]  slot;
        logic [23:0] frame_length;
        logic        keyframe;
        logic [47:0] time_us;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  granted_slot;
        logic [23:0] capacity_out;
        logic [23:0] out_length;
        logic [31:0] sequence_res;
        logic [2:0]  payload_out;
        logic        keyframe_out;
        logic [47:0] time_out;
    } out_item_t;

endpackage

### rtl/fsmgr_req_if.sv
interface fsmgr_req_if;
    logic                valid;
    logic                ready;
    fsmgr_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/fsmgr_rsp_if.sv
interface fsmgr_rsp_if;
    logic                 valid;
    logic                 ready;
    fsmgr_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/frame_slot_manager.sv
// Channel | Dir | Payload      | Transfer
// --------+-----+--------------+---------------------------
// req     | in  | in_item_t    | valid & ready at clk rise
// rsp     | out | out_item_t   | valid & ready at clk rise
//
// One operation at a time. A sequencer walks one slot entry per cycle
// through a single slot read/write port (scan index). Rejected ops go straight
// to done; publish/acquire/release pass the execute step; install clears each
// slot, begin write scans for a free slot, quiesce checks ref counts and then
// clears lengths. req.ready is high only while the sequencer is idle and rises
// as a result loads on rsp; a finished result waits in the rsp output register,
// so the next op is taken while rsp is stalled; its load waits until rsp drains.
// rst_n is asynchronous, active low; it clears all store state to zero.
module frame_slot_manager (
    input  logic               clk,
    input  logic               rst_n,
    fsmgr_req_if.sink          req,
    fsmgr_rsp_if.source        rsp
);

`include "frame_slot_manager_defines.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;  // install: clear slot entries
    localparam logic [2:0] S_QSCAN = 3'd2;  // quiesce: check ref counts
    localparam logic [2:0] S_QCLR  = 3'd3;  // quiesce: clear lengths
    localparam logic [2:0] S_WSCAN = 3'd4;  // begin write: find free slot
    localparam logic [2:0] S_EXEC  = 3'd5;  // publish / acquire / release
    localparam logic [2:0] S_DONE  = 3'd6;  // hand result to output register

    localparam logic [fsmgr_pkg::IDX_W-1:0] LAST_IDX =
        fsmgr_pkg::IDX_W'(fsmgr_pkg::SLOTS - 1);
    localparam logic [3:0] SLOTS4 = 4'(fsmgr_pkg::SLOTS);

    // Sequencer and held operation
    logic [2:0]                      state_reg, state_next;
    logic [fsmgr_pkg::IDX_W-1:0]     scan_reg, scan_next;
    fsmgr_pkg::in_item_t             item_reg, item_next;
    fsmgr_pkg::out_item_t            res_reg, res_next;

    // Store globals
    logic [3:0]                      active_reg, active_next;
    logic [23:0]                     cap_reg, cap_next;
    logic [2:0]                      payload_reg, payload_next;
    logic                            front_valid_reg, front_valid_next;
    logic [fsmgr_pkg::IDX_W-1:0]     front_idx_reg, front_idx_next;
    logic [31:0]                     seq_reg, seq_next;

    // Output register
    logic                            out_valid_reg, out_valid_next;
    fsmgr_pkg::out_item_t            out_data_reg, out_data_next;

    // Per-slot entries, one port addressed by scan_reg
    logic [23:0]                     slot_len_reg  [fsmgr_pkg::SLOTS];
    logic [7:0]                      slot_ref_reg  [fsmgr_pkg::SLOTS];
    logic                            slot_key_reg  [fsmgr_pkg::SLOTS];
    logic [47:0]                     slot_time_reg [fsmgr_pkg::SLOTS];

    logic [23:0] len_rd;
    logic [7:0]  ref_rd;
    logic        key_rd;
    logic [47:0] time_rd;

    logic        wr_len_en, wr_ref_en, wr_key_en, wr_time_en;
    logic [23:0] wr_len;
    logic [7:0]  wr_ref;
    logic        wr_key;
    logic        is_front;

    assign len_rd  = slot_len_reg[scan_reg];
    assign ref_rd  = slot_ref_reg[scan_reg];
    assign key_rd  = slot_key_reg[scan_reg];
    assign time_rd = slot_time_reg[scan_reg];
    assign is_front = front_valid_reg && (front_idx_reg == scan_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        state_next       = state_reg;
        scan_next        = scan_reg;
        item_next        = item_reg;
        res_next         = res_reg;
        active_next      = active_reg;
        cap_next         = cap_reg;
        payload_next     = payload_reg;
        front_valid_next = front_valid_reg;
        front_idx_next   = front_idx_reg;
        seq_next         = seq_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        wr_len_en        = 1'b0;
        wr_ref_en        = 1'b0;
        wr_key_en        = 1'b0;
        wr_time_en       = 1'b0;
        wr_len           = 24'd0;
        wr_ref           = 8'd0;
        wr_key           = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    item_next       = req.data;
                    res_next        = '0;
                    res_next.status = fsmgr_pkg::ST_INVAL;
                    scan_next       = '0;
                    state_next      = S_DONE;
                    case (req.data.mode)
                        fsmgr_pkg::MODE_INSTALL:
                        begin
                            if (req.data.slot_count != 4'd0 &&
                                req.data.slot_count <= SLOTS4)
                            begin
                                state_next = S_CLEAR;
                            end
                        end
                        fsmgr_pkg::MODE_QUIESCE:
                        begin
                            state_next = S_QSCAN;
                        end
                        fsmgr_pkg::MODE_BEGIN:
                        begin
                            if (active_reg == 4'd0)
                            begin
                                res_next.status = fsmgr_pkg::ST_NOSLOTS;
                            end
                            else
                            begin
                                state_next = S_WSCAN;
                            end
                        end
                        fsmgr_pkg::MODE_ACQUIRE:
                        begin
                            scan_next  = front_idx_reg;
                            state_next = S_EXEC;
                        end
                        fsmgr_pkg::MODE_PUBLISH, fsmgr_pkg::MODE_RELEASE:
                        begin
                            if (req.data.slot < SLOTS4)
                            begin
                                scan_next  = req.data.slot[fsmgr_pkg::IDX_W-1:0];
                                state_next = S_EXEC;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                wr_len_en = 1'b1;
                wr_ref_en = 1'b1;
                wr_key_en = 1'b1;
                if (scan_reg == LAST_IDX)
                begin
                    active_next      = item_reg.slot_count;
                    cap_next         = item_reg.capacity;
                    payload_next     = item_reg.payload_kind;
                    front_valid_next = 1'b0;
                    front_idx_next   = '0;
                    seq_next         = seq_reg + 32'd1;
                    res_next.status  = fsmgr_pkg::ST_OK;
                    state_next       = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_QSCAN:
            begin
                if (ref_rd != 8'd0)
                begin
                    res_next.status = fsmgr_pkg::ST_BUSY;
                    state_next      = S_DONE;
                end
                else if (scan_reg == LAST_IDX)
                begin
                    scan_next  = '0;
                    state_next = S_QCLR;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_QCLR:
            begin
                wr_len_en = 1'b1;
                if (scan_reg == LAST_IDX)
                begin
                    front_valid_next = 1'b0;
                    front_idx_next   = '0;
                    payload_next     = 3'd0;
                    active_next      = 4'd0;
                    cap_next         = 24'd0;
                    res_next.status  = fsmgr_pkg::ST_OK;
                    state_next       = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_WSCAN:
            begin
                if (4'(scan_reg) >= active_reg)
                begin
                    res_next.status = fsmgr_pkg::ST_NOFREE;
                    state_next      = S_DONE;
                end
                else if (ref_rd == 8'd0 && !is_front)
                begin
                    res_next.status       = fsmgr_pkg::ST_OK;
                    res_next.granted_slot = 3'(scan_reg);
                    res_next.capacity_out = cap_reg;
                    state_next            = S_DONE;
                end
                else if (scan_reg == LAST_IDX)
                begin
                    res_next.status = fsmgr_pkg::ST_NOFREE;
                    state_next      = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                case (item_reg.mode)
                    fsmgr_pkg::MODE_PUBLISH:
                    begin
                        wr_len_en        = 1'b1;
                        wr_len           = item_reg.frame_length;
                        wr_key_en        = 1'b1;
                        wr_key           = item_reg.keyframe;
                        wr_time_en       = 1'b1;
                        front_valid_next = 1'b1;
                        front_idx_next   = scan_reg;
                        seq_next         = seq_reg + 32'd1;
                        res_next.status  = fsmgr_pkg::ST_OK;
                    end
                    fsmgr_pkg::MODE_ACQUIRE:
                    begin
                        if (!front_valid_reg || 4'(scan_reg) >= active_reg ||
                            len_rd == 24'd0 || len_rd > cap_reg)
                        begin
                            res_next.status = fsmgr_pkg::ST_NOFRAME;
                        end
                        else
                        begin
                            wr_ref_en             = 1'b1;
                            wr_ref                = (ref_rd != fsmgr_pkg::REF_MAX) ?
                                                    ref_rd + 8'd1 : ref_rd;
                            res_next.status       = fsmgr_pkg::ST_OK;
                            res_next.granted_slot = 3'(scan_reg);
                            res_next.out_length   = len_rd;
                            res_next.sequence_res = seq_reg;
                            res_next.payload_out  = payload_reg;
                            res_next.keyframe_out = key_rd;
                            res_next.time_out     = time_rd;
                        end
                    end
                    default:
                    begin
                        // release: a count at zero stays zero
                        wr_ref_en       = (ref_rd != 8'd0);
                        wr_ref          = ref_rd - 8'd1;
                        res_next.status = fsmgr_pkg::ST_OK;
                    end
                endcase
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            scan_reg        <= '0;
            active_reg      <= 4'd0;
            cap_reg         <= 24'd0;
            payload_reg     <= 3'd0;
            front_valid_reg <= 1'b0;
            front_idx_reg   <= '0;
            seq_reg         <= 32'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_reg        <= scan_next;
            active_reg      <= active_next;
            cap_reg         <= cap_next;
            payload_reg     <= payload_next;
            front_valid_reg <= front_valid_next;
            front_idx_reg   <= front_idx_next;
            seq_reg         <= seq_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // Slot entries: single write port at scan_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fsmgr_pkg::SLOTS; i++)
            begin
                slot_len_reg[i]  <= 24'd0;
                slot_ref_reg[i]  <= 8'd0;
                slot_key_reg[i]  <= 1'b0;
                slot_time_reg[i] <= 48'd0;
            end
        end
        else
        begin
            if (wr_len_en)
            begin
                slot_len_reg[scan_reg] <= wr_len;
            end
            if (wr_ref_en)
            begin
                slot_ref_reg[scan_reg] <= wr_ref;
            end
            if (wr_key_en)
            begin
                slot_key_reg[scan_reg] <= wr_key;
            end
            if (wr_time_en)
            begin
                slot_time_reg[scan_reg] <= item_reg.time_us;
            end
        end
    end

    `FSMGR_ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, state_reg != S_IDLE, "accepted op did not start")
    `FSMGR_ASSERT_NOW(a_active_bound, 1'b1, active_reg <= SLOTS4, "active slot count above SLOTS")
    `FSMGR_ASSERT_NOW(a_load_from_done, $rose(out_valid_reg), $past(state_reg) == S_DONE, "result loaded outside done step")
    `FSMGR_ASSERT_NEXT(a_acquire_refs, state_reg == S_EXEC && item_reg.mode == fsmgr_pkg::MODE_ACQUIRE && res_next.status == fsmgr_pkg::ST_OK, slot_ref_reg[front_idx_reg] != 8'd0, "acquired slot not referenced")

endmodule

### tb/frame_slot_manager_tb.sv
// Frame slot manager testbench.
// Stimulus is queued up front by one initial block. A clocked driver feeds
// the request channel in bursts, and a clocked stall generator throttles the
// response channel. The scoreboard keeps its own copy of the slot store. It
// predicts each accepted operation and compares each response transfer field
// by field, in order.
module frame_slot_manager_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsmgr_pkg::*;

    // Modes the block does not define; both must answer invalid argument.
    localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

    localparam int RANDOM_OPS   = 680;   // plus the refcount saturation burst
    localparam int SAT_ACQUIRES = 260;   // past the 255 ceiling on purpose
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

    logic clk;
    logic rst_n;

    fsmgr_req_if req_ch ();
    fsmgr_rsp_if rsp_ch ();

    frame_slot_manager u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive every block input to a known value at time zero.
    // The clocked blocks below take over from the first edge.
    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the slot store, updated in transfer order
    // ------------------------------------------------------------------
    logic [3:0]  mdl_active;
    logic [23:0] mdl_capacity;
    logic [2:0]  mdl_payload;
    logic        mdl_front_valid;
    logic [2:0]  mdl_front_idx;
    logic [31:0] mdl_seq;
    logic [23:0] mdl_len  [SLOTS];
    logic [7:0]  mdl_refs [SLOTS];
    logic        mdl_key  [SLOTS];
    logic [47:0] mdl_time [SLOTS];

    in_item_t  pending_ops[$];        // operations not yet offered to the block
    out_item_t predicted_replies[$];  // accepted operations awaiting their reply

    int mismatches;
    int sat_hits;                     // acquires that found the count at the ceiling
    int ok_replies;
    int mode_hist [8];

    initial
    begin
        mdl_active      = '0;
        mdl_capacity    = '0;
        mdl_payload     = '0;
        mdl_front_valid = 1'b0;
        mdl_front_idx   = '0;
        mdl_seq         = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            mdl_len[i]  = '0;
            mdl_refs[i] = '0;
            mdl_key[i]  = 1'b0;
            mdl_time[i] = '0;
        end
        mismatches = 0;
        sat_hits   = 0;
        ok_replies = 0;
        foreach (mode_hist[m])
            mode_hist[m] = 0;
    end

    // Applies one operation to the shadow store and returns the reply it earns.
    function automatic out_item_t execute_store_op(in_item_t op);
        out_item_t r;
        int        f;
        int        grant;
        bit        busy;
        bit        found;
        r     = '0;
        busy  = 1'b0;
        found = 1'b0;
        grant = 0;
        case (op.mode)
            MODE_INSTALL:
            begin
                if (op.slot_count == 0 || op.slot_count > SLOTS)
                    r.status = ST_INVAL;
                else
                begin
                    // times survive an install; everything else per slot is wiped
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        mdl_len[i]  = '0;
                        mdl_refs[i] = '0;
                        mdl_key[i]  = 1'b0;
                    end
                    mdl_active      = op.slot_count;
                    mdl_capacity    = op.capacity;
                    mdl_payload     = op.payload_kind;
                    mdl_front_valid = 1'b0;
                    mdl_front_idx   = '0;
                    mdl_seq         = mdl_seq + 32'd1;
                    r.status        = ST_OK;
                end
            end
            MODE_QUIESCE:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (mdl_refs[i] != 0)
                        busy = 1'b1;
                if (busy)
                    r.status = ST_BUSY;
                else
                begin
                    // keyframe marks, times and sequence are kept
                    mdl_front_valid = 1'b0;
                    mdl_front_idx   = '0;
                    mdl_payload     = '0;
                    for (int i = 0; i < SLOTS; i++)
                        mdl_len[i] = '0;
                    mdl_active   = '0;
                    mdl_capacity = '0;
                    r.status     = ST_OK;
                end
            end
            MODE_BEGIN:
            begin
                if (mdl_active == 0)
                    r.status = ST_NOSLOTS;
                else
                begin
                    // lowest present slot that nobody reads and is not the front
                    for (int i = 0; i < int'(mdl_active) && i < SLOTS; i++)
                        if (!found && mdl_refs[i] == 0 &&
                            !(mdl_front_valid && int'(mdl_front_idx) == i))
                        begin
                            found = 1'b1;
                            grant = i;
                        end
                    if (!found)
                        r.status = ST_NOFREE;
                    else
                    begin
                        r.status       = ST_OK;
                        r.granted_slot = 3'(grant);
                        r.capacity_out = mdl_capacity;
                    end
                end
            end
            MODE_PUBLISH:
            begin
                if (op.slot >= SLOTS)
                    r.status = ST_INVAL;
                else
                begin
                    // a slot beyond the installed count is still recorded
                    mdl_len[op.slot]  = op.frame_length;
                    mdl_key[op.slot]  = op.keyframe;
                    mdl_time[op.slot] = op.time_us;
                    mdl_front_valid   = 1'b1;
                    mdl_front_idx     = 3'(op.slot);
                    mdl_seq           = mdl_seq + 32'd1;
                    r.status          = ST_OK;
                end
            end
            MODE_ACQUIRE:
            begin
                f = int'(mdl_front_idx);
                if (!mdl_front_valid || f >= SLOTS || f >= int'(mdl_active) ||
                    mdl_len[f] == 0 || mdl_len[f] > mdl_capacity)
                    r.status = ST_NOFRAME;
                else
                begin
                    if (mdl_refs[f] != REF_MAX)
                        mdl_refs[f] = mdl_refs[f] + 8'd1;
                    else
                        sat_hits++;
                    r.status       = ST_OK;
                    r.granted_slot = 3'(f);
                    r.out_length   = mdl_len[f];
                    r.sequence_res = mdl_seq;
                    r.payload_out  = mdl_payload;
                    r.keyframe_out = mdl_key[f];
                    r.time_out     = mdl_time[f];
                end
            end
            MODE_RELEASE:
            begin
                if (op.slot >= SLOTS)
                    r.status = ST_INVAL;
                else
                begin
                    // releasing an idle slot is harmless
                    if (mdl_refs[op.slot] != 0)
                        mdl_refs[op.slot] = mdl_refs[op.slot] - 8'd1;
                    r.status = ST_OK;
                end
            end
            default:
                r.status = ST_INVAL;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin : req_driver
        logic     nxt_valid;
        in_item_t nxt_data;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            // previous item taken (or none offered): choose what comes next
            nxt_valid = 1'b0;
            nxt_data  = req_ch.data;
            if (gap_left > 0)
                gap_left--;
            else if (pending_ops.size() != 0)
            begin
                nxt_valid = 1'b1;
                nxt_data  = pending_ops.pop_front();
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       burst_left = $urandom_range(1, 3);
                        3:       burst_left = $urandom_range(40, 120);
                        default: burst_left = $urandom_range(4, 20);
                    endcase
                    gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 12)
                                                           : $urandom_range(0, 1);
                end
            end
            req_ch.valid <= nxt_valid;
            req_ch.data  <= nxt_data;
        end
    end

    // ------------------------------------------------------------------
    // Response back-pressure: phases of free flow, light, heavy and
    // periodic stalls, each lasting a random number of cycles
    // ------------------------------------------------------------------
    int stall_phase;
    int phase_left;

    always @(posedge clk or negedge rst_n)
    begin : rsp_stall
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_phase = 0;
            phase_left  = 0;
        end
        else
        begin
            if (phase_left == 0)
            begin
                stall_phase = $urandom_range(0, 3);
                phase_left  = $urandom_range(32, 300);
            end
            else
                phase_left--;
            case (stall_phase)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
                2:       rsp_ch.ready <= ($urandom_range(0, 9) < 2);
                default: rsp_ch.ready <= (phase_left % 5 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: predict on request transfer, compare on response transfer.
    // Prediction runs first so ordering within an edge never matters.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predicted_replies.push_back(execute_store_op(req_ch.data));
                mode_hist[req_ch.data.mode]++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $error("response transfer with no operation outstanding");
                    mismatches++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (want.status == ST_OK)
                        ok_replies++;
                    check_field("status",       want.status,       rsp_ch.data.status);
                    check_field("granted_slot", want.granted_slot, rsp_ch.data.granted_slot);
                    check_field("capacity_out", want.capacity_out, rsp_ch.data.capacity_out);
                    check_field("out_length",   want.out_length,   rsp_ch.data.out_length);
                    check_field("sequence_res", want.sequence_res, rsp_ch.data.sequence_res);
                    check_field("payload_out",  want.payload_out,  rsp_ch.data.payload_out);
                    check_field("keyframe_out", want.keyframe_out, rsp_ch.data.keyframe_out);
                    check_field("time_out",     want.time_out,     rsp_ch.data.time_out);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_op(logic [2:0] mode, logic [3:0] cnt, logic [23:0] cap,
                          logic [2:0] kind, logic [3:0] sl, logic [23:0] len,
                          logic key, logic [47:0] tus);
        in_item_t op;
        op.mode         = mode;
        op.slot_count   = cnt;
        op.capacity     = cap;
        op.payload_kind = kind;
        op.slot         = sl;
        op.frame_length = len;
        op.keyframe     = key;
        op.time_us      = tus;
        pending_ops.push_back(op);
    endtask

    initial
    begin : stimulus
        int unsigned gen_slots;
        int unsigned gen_cap;
        int unsigned pick;
        int          sat_at;
        logic [2:0]  mode;
        logic [3:0]  cnt;
        logic [23:0] cap;
        logic [2:0]  kind;
        logic [3:0]  sl;
        logic [23:0] len;
        logic        key;
        logic [47:0] tus;

        // --- directed corners ---
        // empty store: nothing to acquire, no slots, quiesce is a no-op
        add_op(MODE_ACQUIRE,  4'd0, '0, '0, 4'd0, '0, 1'b0, '0);
        add_op(MODE_BEGIN,    4'd0, '0, '0, 4'd0, '0, 1'b0, '0);
        add_op(MODE_QUIESCE,  4'd0, '0, '0, 4'd0, '0, 1'b0, '0);
        add_op(MODE_UNDEF_LO, 4'd0, '0, '0, 4'd0, '0, 1'b0, '0);
        add_op(MODE_UNDEF_HI, 4'hF, '1, '1, 4'hF, '1, 1'b1, '1);
        // bad install counts
        add_op(MODE_INSTALL,  4'd0, 24'd100, 3'd1, 4'd0, '0, 1'b0, '0);
        add_op(MODE_INSTALL,  4'hF, 24'd100, 3'd1, 4'd0, '0, 1'b0, '0);
        add_op(MODE_INSTALL,  4'(SLOTS + 1), 24'd100, 3'd1, 4'd0, '0, 1'b0, '0);
        // full store at maximum capacity
        add_op(MODE_INSTALL,  4'(SLOTS), '1, 3'd7, 4'd0, '0, 1'b0, '0);
        add_op(MODE_PUBLISH,  4'd0, '0, '0, 4'hF, 24'd10, 1'b1, '1);
        add_op(MODE_PUBLISH,  4'd0, '0, '0, 4'd0, 24'd0, 1'b1, '1);
        add_op(MODE_ACQUIRE,  4'd0, '0, '0, 4'd0, '0, 1'b0, '0);   // zero length
        add_op(MODE_PUBLISH,  4'd0, '0, '0, 4'd1, '1, 1'b1, '1);
        add_op(MODE_ACQUIRE,  4'd0, '0, '0, 4'd0, '0, 1'b0, '0);   // all-ones reply
        add_op(MODE_BEGIN,    4'd0, '0, '0, 4'd0, '0, 1'b0, '0);
        add_op(MODE_QUIESCE,  4'd0, '0, '0, 4'd0, '0, 1'b0, '0);   // busy
        add_op(MODE_RELEASE,  4'd0, '0, '0, 4'hF, '0, 1'b0, '0);
        add_op(MODE_RELEASE,  4'd0, '0, '0, 4'd1, '0, 1'b0, '0);
        add_op(MODE_RELEASE,  4'd0, '0, '0, 4'd1, '0, 1'b0, '0);   // already zero
        // one-slot store: front on an absent slot, then an oversize frame
        add_op(MODE_INSTALL,  4'd1, 24'd100, 3'd0, 4'd0, '0, 1'b0, '0);
        add_op(MODE_PUBLISH,  4'd0, '0, '0, 4'(SLOTS - 1), 24'd50, 1'b0, 48'd7);
        add_op(MODE_ACQUIRE,  4'd0, '0, '0, 4'd0, '0, 1'b0, '0);
        add_op(MODE_BEGIN,    4'd0, '0, '0, 4'd0, '0, 1'b0, '0);
        add_op(MODE_PUBLISH,  4'd0, '0, '0, 4'd0, 24'd101, 1'b0, 48'd9);
        add_op(MODE_ACQUIRE,  4'd0, '0, '0, 4'd0, '0, 1'b0, '0);
        add_op(MODE_PUBLISH,  4'd0, '0, '0, 4'd0, 24'd100, 1'b1, 48'd11);
        add_op(MODE_ACQUIRE,  4'd0, '0, '0, 4'd0, '0, 1'b0, '0);
        add_op(MODE_BEGIN,    4'd0, '0, '0, 4'd0, '0, 1'b0, '0);   // no free slot
        add_op(MODE_RELEASE,  4'd0, '0, '0, 4'd0, '0, 1'b0, '0);
        add_op(MODE_QUIESCE,  4'd0, '0, '0, 4'd0, '0, 1'b0, '0);

        // --- random operations, biased toward a live store ---
        gen_slots = 0;
        gen_cap   = 0;
        sat_at    = $urandom_range(100, RANDOM_OPS - 100);
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n == sat_at)
            begin
                // drive one slot's reference count into the ceiling and back
                sl  = 4'($urandom_range(0, SLOTS - 1));
                len = 24'($urandom_range(1, 24'hFFFFFF));
                add_op(MODE_INSTALL, 4'(SLOTS), '1, 3'($urandom), '0, '0, 1'b0, '0);
                add_op(MODE_PUBLISH, '0, '0, '0, sl, len, 1'($urandom),
                       48'({$urandom, $urandom}));
                repeat (SAT_ACQUIRES)
                    add_op(MODE_ACQUIRE, '0, '0, '0, '0, '0, 1'b0, '0);
                add_op(MODE_QUIESCE, '0, '0, '0, '0, '0, 1'b0, '0);
                add_op(MODE_BEGIN,   '0, '0, '0, '0, '0, 1'b0, '0);
                repeat (SAT_ACQUIRES)
                    add_op(MODE_RELEASE, '0, '0, '0, sl, '0, 1'b0, '0);
                add_op(MODE_QUIESCE, '0, '0, '0, '0, '0, 1'b0, '0);
                gen_slots = 0;
                gen_cap   = 0;
            end

            // unused fields carry random noise
            cnt  = 4'($urandom);
            cap  = 24'($urandom);
            kind = 3'($urandom);
            sl   = 4'($urandom);
            len  = 24'($urandom);
            key  = 1'($urandom);
            tus  = 48'({$urandom, $urandom});
            pick = $urandom_range(0, 99);

            if (pick < 6)
            begin
                mode = MODE_INSTALL;
                cnt  = 4'($urandom_range(1, SLOTS));
                if ($urandom_range(0, 1) == 0)
                    cap = 24'($urandom_range(1, 4096));
                gen_slots = cnt;
                gen_cap   = cap;
            end
            else if (pick < 8)
            begin
                mode = MODE_INSTALL;
                cnt  = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(SLOTS + 1, 15));
            end
            else if (pick < 12)
                mode = MODE_QUIESCE;
            else if (pick < 28)
                mode = MODE_BEGIN;
            else if (pick < 54)
            begin
                mode = MODE_PUBLISH;
                pick = $urandom_range(0, 99);
                if (pick < 85 && gen_slots != 0)
                    sl = 4'($urandom_range(0, gen_slots - 1));
                else if (pick < 95)
                    sl = 4'($urandom_range(0, SLOTS - 1));
                else
                    sl = 4'($urandom_range(SLOTS, 15));
                pick = $urandom_range(0, 99);
                if (pick < 80 && gen_cap != 0)
                    len = 24'($urandom_range(1, gen_cap));
                else if (pick < 88)
                    len = '0;
            end
            else if (pick < 78)
                mode = MODE_ACQUIRE;
            else if (pick < 97)
            begin
                mode = MODE_RELEASE;
                sl   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(SLOTS, 15))
                                                   : 4'($urandom_range(0, SLOTS - 1));
            end
            else
                mode = ($urandom_range(0, 1) == 0) ? MODE_UNDEF_LO : MODE_UNDEF_HI;

            add_op(mode, cnt, cap, kind, sl, len, key, tus);
        end

        // --- wind down: everything offered, everything answered, then settle ---
        @(posedge clk);
        while (!rst_n || pending_ops.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (predicted_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d ops: install %0d, quiesce %0d, begin %0d, publish %0d, acquire %0d,",
                 mode_hist[0] + mode_hist[1] + mode_hist[2] + mode_hist[3] + mode_hist[4] +
                 mode_hist[5] + mode_hist[6] + mode_hist[7], mode_hist[0], mode_hist[1],
                 mode_hist[2], mode_hist[3], mode_hist[4]);
        $display("release %0d, undefined %0d; %0d ok, %0d saturated acquires, %0d mismatches",
                 mode_hist[5], mode_hist[6] + mode_hist[7], ok_replies, sat_hits, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin : watchdog
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
